>>> design/ccs_pkg.sv
// ============================================================================
// ccs_pkg: shared definitions of the corner-cutting smoother
// Default sizes, the width of the depth register and the control word that
// the top level hands to every smoothing cell.
// ============================================================================
package ccs_pkg;

    localparam int MAX_DEPTH_DEF   = 4;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int DEPTH_W         = 3;

    typedef struct packed {
        logic active;   // cell takes part in smoothing at the current depth
        logic clear;    // forget the previous vertex
    } ccs_cell_ctrl_t;

endpackage

>>> design/ccs_in_if.sv
// ============================================================================
// ccs_in_if: vertex input channel
// Valid/ready channel carrying one polyline vertex and its last flag.
// ============================================================================
interface ccs_in_if #(
    parameter int W = ccs_pkg::COORD_WIDTH_DEF
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] x_in;
    logic signed [W-1:0] y_in;
    logic                last_in;

    modport source (output valid, output x_in, output y_in, output last_in, input ready);
    modport sink   (input valid, input x_in, input y_in, input last_in, output ready);
endinterface

>>> design/ccs_out_if.sv
// ============================================================================
// ccs_out_if: smoothed vertex output channel
// Valid/ready channel carrying one smoothed vertex and its last flag.
// ============================================================================
interface ccs_out_if #(
    parameter int W = ccs_pkg::COORD_WIDTH_DEF
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] x_out;
    logic signed [W-1:0] y_out;
    logic                last_out;

    modport source (output valid, output x_out, output y_out, output last_out, input ready);
    modport sink   (input valid, input x_out, input y_out, input last_out, output ready);
endinterface

>>> design/ccs_cell.sv
// ============================================================================
// ccs_cell: one corner-cutting pass
// Holds one incoming vertex and the previous vertex of the line, and emits
// the refined points into its own output register, one per cycle unless stalled.
// ============================================================================
module ccs_cell #(
    parameter int W = ccs_pkg::COORD_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ccs_pkg::ccs_cell_ctrl_t ctrl,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic signed [W-1:0]    in_x,
    input  logic signed [W-1:0]    in_y,
    input  logic                   in_last,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic signed [W-1:0]    out_x,
    output logic signed [W-1:0]    out_y,
    output logic                   out_last
);
    import ccs_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_BYPASS    = 6'b000010,
        ST_PASS      = 6'b000100,
        ST_NEAR_PREV = 6'b001000,
        ST_NEAR_CUR  = 6'b010000,
        ST_TAIL      = 6'b100000
    } cell_state_t;

    // floor((3*a + b) / 4), always fits back into W bits
    function automatic logic signed [W-1:0] mix3(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
        logic signed [W+1:0] ae;
        logic signed [W+1:0] be;
        logic signed [W+1:0] s;
        ae = {{2{a[W-1]}}, a};
        be = {{2{b[W-1]}}, b};
        s  = (ae <<< 1) + ae + be;
        return s[W+1:2];
    endfunction

    cell_state_t         state_reg, state_next;
    logic signed [W-1:0] cur_x_reg, cur_y_reg;
    logic                cur_last_reg;
    logic signed [W-1:0] prev_x_reg, prev_y_reg;
    logic                has_prev_reg, has_prev_next;
    logic                ov_reg;
    logic signed [W-1:0] ox_reg, oy_reg;
    logic                olast_reg;

    logic                out_load;
    logic                item_done;
    logic                in_fire;
    logic                hp_eff;
    logic signed [W-1:0] cand_x, cand_y;
    logic                cand_last;

    assign out_load = (state_reg != ST_IDLE) && (!ov_reg || out_ready);

    always_comb
    begin
        cand_x    = cur_x_reg;
        cand_y    = cur_y_reg;
        cand_last = 1'b0;
        unique case (state_reg)
            ST_BYPASS:    cand_last = cur_last_reg;
            ST_PASS:      cand_last = 1'b0;
            ST_NEAR_PREV:
            begin
                cand_x = mix3(prev_x_reg, cur_x_reg);
                cand_y = mix3(prev_y_reg, cur_y_reg);
            end
            ST_NEAR_CUR:
            begin
                cand_x = mix3(cur_x_reg, prev_x_reg);
                cand_y = mix3(cur_y_reg, prev_y_reg);
            end
            ST_TAIL:      cand_last = 1'b1;
            default:      cand_last = 1'b0;
        endcase
    end

    // The item is finished when its final point moves to the output register.
    assign item_done = out_load &&
                       ((state_reg == ST_BYPASS) || (state_reg == ST_TAIL) ||
                        (((state_reg == ST_PASS) || (state_reg == ST_NEAR_CUR)) &&
                         !cur_last_reg));

    assign in_ready = (state_reg == ST_IDLE) || item_done;
    assign in_fire  = in_valid && in_ready;

    // A vertex accepted in the cycle the previous one finishes sees its update.
    assign hp_eff = (item_done && (state_reg != ST_BYPASS)) ? !cur_last_reg : has_prev_reg;

    always_comb
    begin
        state_next = state_reg;
        if (in_fire)
        begin
            if (!ctrl.active)
                state_next = ST_BYPASS;
            else if (hp_eff)
                state_next = ST_NEAR_PREV;
            else
                state_next = ST_PASS;
        end
        else if (item_done)
            state_next = ST_IDLE;
        else if (out_load)
        begin
            unique case (state_reg)
                ST_NEAR_PREV:        state_next = ST_NEAR_CUR;
                ST_PASS, ST_NEAR_CUR: state_next = ST_TAIL;
                default:             state_next = state_reg;
            endcase
        end
    end

    always_comb
    begin
        has_prev_next = has_prev_reg;
        if (ctrl.clear)
            has_prev_next = 1'b0;
        else if (item_done && (state_reg != ST_BYPASS))
            has_prev_next = !cur_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            has_prev_reg <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            has_prev_reg <= has_prev_next;
            if (out_load)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cur_x_reg    <= in_x;
            cur_y_reg    <= in_y;
            cur_last_reg <= in_last;
        end
        if (item_done && (state_reg != ST_BYPASS))
        begin
            prev_x_reg <= cur_x_reg;
            prev_y_reg <= cur_y_reg;
        end
        if (out_load)
        begin
            ox_reg    <= cand_x;
            oy_reg    <= cand_y;
            olast_reg <= cand_last;
        end
    end

    assign out_valid = ov_reg;
    assign out_x     = ox_reg;
    assign out_y     = oy_reg;
    assign out_last  = olast_reg;

    // The second cut point of a segment always follows the first one.
    a_near_cur_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_NEAR_CUR |->
            $past(state_reg) == ST_NEAR_PREV || $past(state_reg) == ST_NEAR_CUR)
        else $error("ccs_cell: second cut point without the first");

    a_tail_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_TAIL |-> cur_last_reg)
        else $error("ccs_cell: closing point on a vertex that is not last");

    a_tail_sets_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && state_reg == ST_TAIL |=> out_valid && out_last)
        else $error("ccs_cell: closing point left without its last flag");

    a_clear_forgets: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.clear |=> !has_prev_reg)
        else $error("ccs_cell: previous vertex kept across a depth write");

    a_bypass_keeps_prev: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_BYPASS && !ctrl.clear |=> $stable(has_prev_reg))
        else $error("ccs_cell: inactive cell changed its line state");

endmodule

>>> design/chaikin_corner_cutting_smoother_unit.sv
// ============================================================================
// chaikin_corner_cutting_smoother_unit: streaming polyline smoother
// Chain of corner-cutting cells; smoothing_depth of them are active.
// ============================================================================
// The unit is a row of MAX_DEPTH smoothing cells, each with its own vertex
// register and output register; the first smoothing_depth cells refine the
// line and the rest pass items straight on. Every cell moves one point per
// cycle while its output is not stalled, so the last cell delivers one
// result per cycle when the output channel is ready. An input vertex expands
// to 2^depth results in steady state (2^(depth+1)-1 on a line's last vertex)
// and to one result at depth zero. In each cell an accepted vertex passes
// through the vertex register and then the output register. Results are
// delivered in order through the output register, which lets the chain keep
// taking vertices while a result waits. Write smoothing_depth only while no
// item is in flight; the write also starts a new line in every cell. Depth
// values above MAX_DEPTH act as MAX_DEPTH.
module chaikin_corner_cutting_smoother_unit #(
    parameter int MAX_DEPTH   = ccs_pkg::MAX_DEPTH_DEF,
    parameter int COORD_WIDTH = ccs_pkg::COORD_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        smoothing_depth_we,
    input  logic [ccs_pkg::DEPTH_W-1:0] smoothing_depth_wdata,
    ccs_in_if.sink                      line_pts,
    ccs_out_if.source                   smooth_pts
);
    import ccs_pkg::*;

    logic [DEPTH_W-1:0] smoothing_depth_reg;

    logic                          lk_valid [0:MAX_DEPTH];
    logic                          lk_ready [0:MAX_DEPTH];
    logic signed [COORD_WIDTH-1:0] lk_x     [0:MAX_DEPTH];
    logic signed [COORD_WIDTH-1:0] lk_y     [0:MAX_DEPTH];
    logic                          lk_last  [0:MAX_DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            smoothing_depth_reg <= '0;
        else if (smoothing_depth_we)
            smoothing_depth_reg <= smoothing_depth_wdata;
    end

    assign lk_valid[0]    = line_pts.valid;
    assign lk_x[0]        = line_pts.x_in;
    assign lk_y[0]        = line_pts.y_in;
    assign lk_last[0]     = line_pts.last_in;
    assign line_pts.ready = lk_ready[0];

    for (genvar i = 0; i < MAX_DEPTH; i++)
    begin : g_cell
        ccs_cell_ctrl_t ctrl;

        assign ctrl = '{active: (DEPTH_W'(i) < smoothing_depth_reg),
                        clear:  smoothing_depth_we};

        ccs_cell #(
            .W (COORD_WIDTH)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .in_valid  (lk_valid[i]),
            .in_ready  (lk_ready[i]),
            .in_x      (lk_x[i]),
            .in_y      (lk_y[i]),
            .in_last   (lk_last[i]),
            .out_valid (lk_valid[i+1]),
            .out_ready (lk_ready[i+1]),
            .out_x     (lk_x[i+1]),
            .out_y     (lk_y[i+1]),
            .out_last  (lk_last[i+1])
        );
    end

    assign smooth_pts.valid     = lk_valid[MAX_DEPTH];
    assign smooth_pts.x_out     = lk_x[MAX_DEPTH];
    assign smooth_pts.y_out     = lk_y[MAX_DEPTH];
    assign smooth_pts.last_out  = lk_last[MAX_DEPTH];
    assign lk_ready[MAX_DEPTH]  = smooth_pts.ready;

endmodule

>>> tb/chaikin_corner_cutting_smoother_unit_test.sv
`timescale 1ns / 1ps
// ============================================================================
// chaikin_corner_cutting_smoother_unit_test: self-checking bench
// Streams polyline vertices through the smoother at a range of depths. The
// scoreboard recomputes every corner-cutting pass and checks each smoothed
// vertex in order. Random idling on both channels and a long output hold-off
// exercise back-pressure.
// ============================================================================

typedef struct packed {
    logic signed [ccs_pkg::COORD_WIDTH_DEF-1:0] x;
    logic signed [ccs_pkg::COORD_WIDTH_DEF-1:0] y;
    logic                                       last;
} vertex_t;

class smoothed_point_board;
    localparam int STAGES = ccs_pkg::MAX_DEPTH_DEF;
    localparam int CW     = ccs_pkg::COORD_WIDTH_DEF;

    int                 depth;
    logic signed [CW-1:0] prev_x [STAGES];
    logic signed [CW-1:0] prev_y [STAGES];
    bit                 has_prev [STAGES];
    vertex_t            expected_pts [$];
    int                 errors;

    function new();
        errors = 0;
        set_depth('0);
    endfunction

    // A depth write also starts a new line in every pass.
    function void set_depth(logic [ccs_pkg::DEPTH_W-1:0] value);
        depth = (value > STAGES) ? STAGES : int'(value);
        for (int s = 0; s < STAGES; s++)
        begin
            prev_x[s]   = '0;
            prev_y[s]   = '0;
            has_prev[s] = 1'b0;
        end
    endfunction

    // floor((wa*a + wb*b) / 4), formed exactly in 64 bits
    function logic signed [CW-1:0] quarter_blend(logic signed [CW-1:0] a, int wa,
                                                 logic signed [CW-1:0] b, int wb);
        longint sum;
        sum = longint'(a) * wa + longint'(b) * wb;
        return CW'(sum >>> 2);
    endfunction

    function void note_vertex(vertex_t v);
        vertex_t chain [$];
        vertex_t staged [$];
        vertex_t pt;
        vertex_t q;
        chain = {chain, v};
        for (int s = 0; s < depth; s++)
        begin
            staged.delete();
            foreach (chain[i])
            begin
                pt = chain[i];
                q.last = 1'b0;
                if (!has_prev[s])
                begin
                    q.x = pt.x;
                    q.y = pt.y;
                    staged = {staged, q};
                end
                else
                begin
                    q.x = quarter_blend(prev_x[s], 3, pt.x, 1);
                    q.y = quarter_blend(prev_y[s], 3, pt.y, 1);
                    staged = {staged, q};
                    q.x = quarter_blend(prev_x[s], 1, pt.x, 3);
                    q.y = quarter_blend(prev_y[s], 1, pt.y, 3);
                    staged = {staged, q};
                end
                if (pt.last)
                begin
                    staged = {staged, pt};
                    has_prev[s] = 1'b0;
                    prev_x[s]   = '0;
                    prev_y[s]   = '0;
                end
                else
                begin
                    has_prev[s] = 1'b1;
                    prev_x[s]   = pt.x;
                    prev_y[s]   = pt.y;
                end
            end
            chain = staged;
        end
        expected_pts = {expected_pts, chain};
    endfunction

    function void check_point(vertex_t got);
        vertex_t want;
        if (expected_pts.size() == 0)
        begin
            $error("unexpected smoothed vertex x_out=%0d y_out=%0d last_out=%0b",
                   got.x, got.y, got.last);
            errors++;
            return;
        end
        want = expected_pts.pop_front();
        if (got.x !== want.x)
        begin
            $error("x_out: expected %0d, actual %0d", want.x, got.x);
            errors++;
        end
        if (got.y !== want.y)
        begin
            $error("y_out: expected %0d, actual %0d", want.y, got.y);
            errors++;
        end
        if (got.last !== want.last)
        begin
            $error("last_out: expected %0b, actual %0b", want.last, got.last);
            errors++;
        end
    endfunction

    function int pending();
        return expected_pts.size();
    endfunction
endclass

module chaikin_corner_cutting_smoother_unit_test;
    import ccs_pkg::*;

    localparam int CW          = COORD_WIDTH_DEF;
    localparam int SETTLE      = 2 * MAX_DEPTH_DEF + 12;
    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_OFF    = 300;

    localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

    logic               clk;
    logic               rst_n;
    logic               smoothing_depth_we;
    logic [DEPTH_W-1:0] smoothing_depth_wdata;

    ccs_in_if  #(.W(CW)) line_pts ();
    ccs_out_if #(.W(CW)) smooth_pts ();

    smoothed_point_board board = new();

    int idle_pct;
    int stall_pct;
    bit hold_req;
    int quiet_cycles;

    int idle_tab  [4] = '{0, 52, 0, 17};
    int stall_tab [4] = '{0, 0, 52, 17};
    int depth_tab [8] = '{1, 4, 0, 7, 3, 2, 5, 6};

    chaikin_corner_cutting_smoother_unit #(
        .MAX_DEPTH   (MAX_DEPTH_DEF),
        .COORD_WIDTH (CW)
    ) dut (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .smoothing_depth_we    (smoothing_depth_we),
        .smoothing_depth_wdata (smoothing_depth_wdata),
        .line_pts              (line_pts),
        .smooth_pts            (smooth_pts)
    );

    initial clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Output side: random stalls, plus one long hold-off on request.
    initial
    begin
        int hold_left;
        bit hold_used;
        hold_left = 0;
        hold_used = 1'b0;
        smooth_pts.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_used)
            begin
                hold_left = HOLD_OFF;
                hold_used = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                smooth_pts.ready <= 1'b0;
            end
            else
                smooth_pts.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Both channels are sampled here so input items are always noted first.
    always @(posedge clk)
    begin
        bit took;
        vertex_t got;
        vertex_t sent;
        took = 1'b0;
        if (rst_n)
        begin
            if (line_pts.valid && line_pts.ready)
            begin
                sent.x    = line_pts.x_in;
                sent.y    = line_pts.y_in;
                sent.last = line_pts.last_in;
                board.note_vertex(sent);
                took = 1'b1;
            end
            if (smooth_pts.valid && smooth_pts.ready)
            begin
                got.x    = smooth_pts.x_out;
                got.y    = smooth_pts.y_out;
                got.last = smooth_pts.last_out;
                board.check_point(got);
                took = 1'b1;
            end
            quiet_cycles = took ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic send_vertex(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                               input logic last);
        while ($urandom_range(99) < idle_pct)
        begin
            line_pts.valid <= 1'b0;
            @(negedge clk);
        end
        line_pts.valid   <= 1'b1;
        line_pts.x_in    <= x;
        line_pts.y_in    <= y;
        line_pts.last_in <= last;
        do
            @(posedge clk);
        while (!line_pts.ready);
        @(negedge clk);
    endtask

    // Stop offering and wait until every smoothed vertex has come out.
    task automatic drain();
        line_pts.valid <= 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_depth(input logic [DEPTH_W-1:0] value);
        drain();
        smoothing_depth_we    <= 1'b1;
        smoothing_depth_wdata <= value;
        board.set_depth(value);
        @(negedge clk);
        smoothing_depth_we    <= 1'b0;
    endtask

    function automatic logic signed [CW-1:0] pick_coord();
        case ($urandom_range(5))
            0:       return C_MAX;
            1:       return C_MIN;
            2:       return CW'($urandom_range(200)) - 100;
            default: return CW'($urandom);
        endcase
    endfunction

    initial
    begin
        int left;
        int len;
        rst_n                 = 1'b0;
        smoothing_depth_we    = 1'b0;
        smoothing_depth_wdata = '0;
        line_pts.valid        = 1'b0;
        line_pts.x_in         = '0;
        line_pts.y_in         = '0;
        line_pts.last_in      = 1'b0;
        idle_pct              = 0;
        stall_pct             = 0;
        hold_req              = 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Depth zero after reset: vertices pass straight through.
        send_vertex(C_MAX, C_MIN, 1'b0);
        send_vertex(C_MIN, C_MAX, 1'b1);
        send_vertex('0, -1, 1'b0);
        send_vertex(-1, '0, 1'b1);

        // One pass: a lone vertex comes out twice; extremes and negative floors.
        write_depth(DEPTH_W'(1));
        send_vertex(5, -7, 1'b1);
        send_vertex(C_MIN, C_MIN, 1'b0);
        send_vertex(C_MAX, C_MAX, 1'b0);
        send_vertex(C_MIN, C_MAX, 1'b1);
        send_vertex(-1, -2, 1'b0);
        send_vertex(2, 1, 1'b1);

        // Full depth.
        write_depth(DEPTH_W'(4));
        send_vertex(C_MAX, C_MIN, 1'b0);
        send_vertex(C_MIN, C_MAX, 1'b0);
        send_vertex(-3, 5, 1'b1);
        send_vertex(C_MAX, C_MAX, 1'b1);

        // Line left open, then a depth above the limit restarts it.
        send_vertex(10, 20, 1'b0);
        send_vertex(30, -40, 1'b0);
        write_depth(DEPTH_W'(7));
        send_vertex(-1, 1, 1'b0);
        send_vertex(C_MIN, C_MAX, 1'b1);

        // Random phases: mostly whole lines, some stray vertices; a phase may
        // end in the middle of a line.
        for (int p = 0; p < 8; p++)
        begin
            write_depth(DEPTH_W'(depth_tab[p]));
            idle_pct  = idle_tab[p % 4];
            stall_pct = stall_tab[p % 4];
            if (p == 4)
                hold_req = 1'b1;
            left = 12;
            while (left > 0)
            begin
                if (p == 2 && left == 7)
                    drain();
                if ($urandom_range(99) < 85)
                begin
                    len = $urandom_range(1, 6);
                    for (int k = 0; k < len && left > 0; k++)
                    begin
                        send_vertex(pick_coord(), pick_coord(), k == len - 1);
                        left--;
                    end
                end
                else
                begin
                    send_vertex(pick_coord(), pick_coord(), 1'($urandom_range(1)));
                    left--;
                end
            end
        end

        drain();
        if (board.errors == 0 && board.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
